FILE: rtl/pfd_pkg.sv
package pfd_pkg;

   localparam int DATA_WIDTH_DEF = 32;

   // shared serial unit widths
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 25;

   localparam int CSR_ADDR_W = 5;

   // register indexes
   localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
   localparam logic [2:0] REG_FEED_FWD   = 3'd3;
   localparam logic [2:0] REG_TAU        = 3'd4;
   localparam logic [2:0] REG_OUT_LIMIT  = 3'd5;
   localparam logic [2:0] REG_INT_LIMIT  = 3'd6;

   typedef struct packed {
      logic [31:0]        prop_gain;
      logic [31:0]        integ_gain;
      logic [31:0]        deriv_gain;
      logic signed [31:0] feed_forward;
      logic [23:0]        filter_tau_us;
      logic [30:0]        output_limit;
      logic [30:0]        integral_limit;
   } cfg_type;

endpackage

FILE: rtl/pfd_mul.sv
module pfd_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pfd_pkg::MUL_A_W-1:0]  a,
   input  logic [pfd_pkg::MUL_B_W-1:0]  b,
   output logic                         busy,
   output logic                         done,
   output logic [pfd_pkg::MUL_P_W-1:0]  prod
);
   import pfd_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]   a_ff, a_in;
   logic [MUL_P_W-1:0]   prod_ff, prod_in;
   logic [MUL_A_W:0]     add;
   logic                 last;

   // shift-add, one multiplier bit per cycle, product shifts right
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      last    = (cnt_ff == CNT_W'(MUL_B_W - 1));
      add     = {1'b0, prod_ff[MUL_P_W-1:MUL_B_W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         prod_in = {{MUL_A_W{1'b0}}, b};
      end else if (busy_ff) begin
         prod_in = {add, prod_ff[MUL_B_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign prod = prod_ff;
endmodule

FILE: rtl/pfd_div.sv
module pfd_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pfd_pkg::DIV_N_W-1:0]  num,
   input  logic [pfd_pkg::DIV_D_W-1:0]  den,
   output logic                         busy,
   output logic                         done,
   output logic [pfd_pkg::DIV_N_W-1:0]  quo
);
   import pfd_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W:0]     trial;
   logic                 ge;
   logic                 last;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      last    = (cnt_ff == CNT_W'(DIV_N_W - 1));
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      ge      = (shifted >= {1'b0, den_ff});
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = den;
         rem_in  = '0;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

FILE: rtl/pfd_csr.sv
module pfd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output pfd_pkg::cfg_type                cfg,
   output logic                            integ_clear
);
   import pfd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        wr_en;
   logic [2:0]  idx;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx   = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_PROP_GAIN:  cfg_in.prop_gain      = csr_pwdata;
            REG_INTEG_GAIN: cfg_in.integ_gain     = csr_pwdata;
            REG_DERIV_GAIN: cfg_in.deriv_gain     = csr_pwdata;
            REG_FEED_FWD:   cfg_in.feed_forward   = csr_pwdata;
            REG_TAU:        cfg_in.filter_tau_us  = csr_pwdata[23:0];
            REG_OUT_LIMIT:  cfg_in.output_limit   = csr_pwdata[30:0];
            REG_INT_LIMIT:  cfg_in.integral_limit = csr_pwdata[30:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_PROP_GAIN:  csr_prdata = cfg_ff.prop_gain;
         REG_INTEG_GAIN: csr_prdata = cfg_ff.integ_gain;
         REG_DERIV_GAIN: csr_prdata = cfg_ff.deriv_gain;
         REG_FEED_FWD:   csr_prdata = cfg_ff.feed_forward;
         REG_TAU:        csr_prdata = {8'd0, cfg_ff.filter_tau_us};
         REG_OUT_LIMIT:  csr_prdata = {1'b0, cfg_ff.output_limit};
         REG_INT_LIMIT:  csr_prdata = {1'b0, cfg_ff.integral_limit};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= 32'd13422;
         cfg_ff.integ_gain     <= 32'd0;
         cfg_ff.deriv_gain     <= 32'd5033;
         cfg_ff.feed_forward   <= 32'sd0;
         cfg_ff.filter_tau_us  <= 24'd1000;
         cfg_ff.output_limit   <= 31'd65536;
         cfg_ff.integral_limit <= 31'd32768000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg         = cfg_ff;
   assign csr_pready  = 1'b1;
   assign integ_clear = wr_en && (idx == REG_INTEG_GAIN);
endmodule

FILE: rtl/pid_filtered_derivative_top.sv
// PID controller with filtered derivative and integrator clamp, Q16.16 data and Q8.24 gains.
// One transaction in gives one drive value out. All products go through one bit-serial
// multiplier and all quotients through one bit-serial restoring divider, one unit at a
// time; with the integral gain at zero the integrator steps are skipped. req_stall is high
// from acceptance until the result is loaded into the output register; the next transaction
// may be accepted while that result waits on rsp_stall. Writing the integral gain clears
// the integrator.
module pid_filtered_derivative_top #(
   parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [31:0]              req_target,
   input  logic signed [31:0]              req_measured,
   input  logic [15:0]                     req_interval_us,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [31:0]              rsp_drive,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pfd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import pfd_pkg::*;

   localparam int ERR_W = (DATA_WIDTH < 33) ? DATA_WIDTH : 33;
   localparam logic signed [33:0] ERR_HI = (34'sd1 <<< (ERR_W - 1)) - 34'sd1;
   localparam logic signed [33:0] ERR_LO = -ERR_HI - 34'sd1;
   localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN48 = -MAX48 - 64'sd1;
   localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] MIN32 = -MAX32 - 64'sd1;
   localparam logic [63:0] MILLION = 64'd1000000;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_P_MUL  = 4'd1;
   localparam logic [3:0] ST_I_MUL  = 4'd2;
   localparam logic [3:0] ST_I_DIV  = 4'd3;
   localparam logic [3:0] ST_IG_MUL = 4'd4;
   localparam logic [3:0] ST_R_MUL  = 4'd5;
   localparam logic [3:0] ST_R_DIV  = 4'd6;
   localparam logic [3:0] ST_L_MUL  = 4'd7;
   localparam logic [3:0] ST_L_DIV  = 4'd8;
   localparam logic [3:0] ST_D_MUL  = 4'd9;
   localparam logic [3:0] ST_SUM    = 4'd10;

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      abs64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > MAX48) r = MAX48;
      if (v < MIN48) r = MIN48;
      sat48 = r[47:0];
   endfunction

   // rounded product scaled by 2^-24, magnitude limited to 48-bit max, sign applied
   function automatic logic signed [47:0] gain_res(input logic [MUL_P_W-1:0] p,
                                                   input logic neg);
      logic [MUL_P_W-1:0] rnd;
      logic [63:0]        m;
      rnd = p + (MUL_P_W'(1) << 23);
      m   = (rnd[MUL_P_W-1:24] > (MUL_P_W-24)'(MAX48)) ? 64'(MAX48) : rnd[87:24];
      gain_res = neg ? 48'(-$signed(m)) : m[47:0];
   endfunction

   cfg_type cfg;
   logic    integ_clear;

   logic [3:0]                state_ff, state_in;
   logic                      wait_ff, wait_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   last_err_ff, last_err_in;
   logic [15:0]               us_ff, us_in;
   logic signed [47:0]        integ_ff, integ_in;
   logic signed [47:0]        ld_ff, ld_in;
   logic signed [47:0]        delta_ff, delta_in;
   logic signed [47:0]        p_ff, p_in;
   logic signed [47:0]        i_ff, i_in;
   logic signed [47:0]        d_ff, d_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]        rsp_drive_ff, rsp_drive_in;

   logic                      mul_start, mul_busy, mul_done;
   logic [MUL_A_W-1:0]        mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic [MUL_P_W-1:0]        mul_prod;
   logic                      div_start, div_busy, div_done;
   logic [DIV_N_W-1:0]        div_num;
   logic [DIV_D_W-1:0]        div_den;
   logic [DIV_N_W-1:0]        div_quo;

   logic                      req_acc;
   logic signed [33:0]        err_raw;
   logic signed [ERR_W:0]     diff;
   logic [DIV_D_W-1:0]        filt_den;
   logic signed [63:0]        qs;
   logic signed [63:0]        acc;
   logic signed [63:0]        lim;

   pfd_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .cfg(cfg), .integ_clear(integ_clear)
   );

   pfd_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .busy(mul_busy), .done(mul_done), .prod(mul_prod)
   );

   pfd_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .busy(div_busy), .done(div_done), .quo(div_quo)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign err_raw   = 34'(req_target) - 34'(req_measured);
   assign diff      = (ERR_W+1)'(err_ff) - (ERR_W+1)'(last_err_ff);
   assign filt_den  = DIV_D_W'(cfg.filter_tau_us) + DIV_D_W'(us_ff);

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      err_in       = err_ff;
      last_err_in  = last_err_ff;
      us_in        = us_ff;
      integ_in     = integ_ff;
      ld_in        = ld_ff;
      delta_in     = delta_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      qs           = '0;
      acc          = '0;
      lim          = '0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (integ_clear) integ_in = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (err_raw > ERR_HI) err_in = ERR_HI[ERR_W-1:0];
               else if (err_raw < ERR_LO) err_in = ERR_LO[ERR_W-1:0];
               else err_in = err_raw[ERR_W-1:0];
               us_in    = (req_interval_us == 16'd0) ? 16'd1 : req_interval_us;
               wait_in  = 1'b0;
               state_in = ST_P_MUL;
            end
         end
         ST_P_MUL: begin
            mul_a = abs64(64'(err_ff));
            mul_b = cfg.prop_gain;
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               p_in    = gain_res(mul_prod, err_ff[ERR_W-1]);
               i_in    = '0;
               wait_in = 1'b0;
               state_in = (cfg.integ_gain != 32'd0) ? ST_I_MUL : ST_R_MUL;
            end
         end
         ST_I_MUL: begin
            mul_a = abs64(64'(err_ff));
            mul_b = MUL_B_W'(us_ff);
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               wait_in  = 1'b0;
               state_in = ST_I_DIV;
            end
         end
         ST_I_DIV: begin
            div_num = mul_prod[DIV_N_W-1:0] + (MILLION >> 1);
            div_den = DIV_D_W'(MILLION);
            if (!wait_ff) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else if (div_done) begin
               qs  = err_ff[ERR_W-1] ? -$signed(div_quo) : $signed(div_quo);
               acc = 64'(sat48(64'(integ_ff) + qs));
               lim = 64'(cfg.integral_limit);
               if (lim != 64'sd0) begin
                  if (acc > lim) acc = lim;
                  if (acc < -lim) acc = -lim;
               end
               integ_in = acc[47:0];
               wait_in  = 1'b0;
               state_in = ST_IG_MUL;
            end
         end
         ST_IG_MUL: begin
            mul_a = abs64(64'(integ_ff));
            mul_b = cfg.integ_gain;
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               i_in     = gain_res(mul_prod, integ_ff[47]);
               wait_in  = 1'b0;
               state_in = ST_R_MUL;
            end
         end
         ST_R_MUL: begin
            mul_a = abs64(64'(diff));
            mul_b = MUL_B_W'(MILLION);
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               wait_in  = 1'b0;
               state_in = ST_R_DIV;
            end
         end
         ST_R_DIV: begin
            div_num = mul_prod[DIV_N_W-1:0] + 64'(us_ff >> 1);
            div_den = DIV_D_W'(us_ff);
            if (!wait_ff) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else if (div_done) begin
               // derivative rate limited to 48-bit magnitude before the filter
               qs = (div_quo > 64'(MAX48)) ? MAX48 : $signed(div_quo);
               if (diff[ERR_W]) qs = -qs;
               delta_in = sat48(qs - 64'(ld_ff));
               wait_in  = 1'b0;
               state_in = ST_L_MUL;
            end
         end
         ST_L_MUL: begin
            mul_a = abs64(64'(delta_ff));
            mul_b = MUL_B_W'(us_ff);
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               wait_in  = 1'b0;
               state_in = ST_L_DIV;
            end
         end
         ST_L_DIV: begin
            div_num = mul_prod[DIV_N_W-1:0] + 64'(filt_den >> 1);
            div_den = filt_den;
            if (!wait_ff) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else if (div_done) begin
               qs       = delta_ff[47] ? -$signed(div_quo) : $signed(div_quo);
               ld_in    = sat48(64'(ld_ff) + qs);
               wait_in  = 1'b0;
               state_in = ST_D_MUL;
            end
         end
         ST_D_MUL: begin
            mul_a = abs64(64'(ld_ff));
            mul_b = cfg.deriv_gain;
            if (!wait_ff) begin
               mul_start = 1'b1;
               wait_in   = 1'b1;
            end else if (mul_done) begin
               d_in     = gain_res(mul_prod, ld_ff[47]);
               wait_in  = 1'b0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            acc = 64'(p_ff) + 64'(i_ff) + 64'(d_ff) + 64'(cfg.feed_forward);
            lim = 64'(cfg.output_limit);
            if (lim != 64'sd0) begin
               if (acc > lim) acc = lim;
               if (acc < -lim) acc = -lim;
            end
            if (acc > MAX32) acc = MAX32;
            if (acc < MIN32) acc = MIN32;
            // wait here while the previous result is still held
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = acc[31:0];
               last_err_in  = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            wait_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         ld_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         ld_ff        <= ld_in;
      end
      err_ff       <= err_in;
      us_ff        <= us_in;
      delta_ff     <= delta_in;
      p_ff         <= p_in;
      i_ff         <= i_in;
      d_ff         <= d_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

`ifndef SYNTHESIS
   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier started while busy");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_busy && div_busy))
      else $error("multiplier and divider busy together");

   a_out_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cfg.output_limit != 31'd0) |->
         ($signed(33'(rsp_drive)) <= $signed({2'b00, cfg.output_limit}) &&
          $signed(33'(rsp_drive)) >= -$signed({2'b00, cfg.output_limit})))
      else $error("drive outside output limit");
`endif
endmodule
